// ===== rtl/core/pcne_pkg.sv =====
// shared types and constants of the next-event selection block
package pcne_pkg;

  localparam int SITE_W = 6;
  localparam int TIME_W = 32;
  localparam int ACT_W  = 7;
  localparam int CFG_IDX_W = 1;

  // item kinds carried on the input tuser
  localparam logic ACT_LOAD = 1'b0;
  localparam logic ACT_STEP = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_SITES = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIME_LIMIT   = 1'b1;

  localparam logic [ACT_W-1:0]  ACTIVE_RESET = 7'd64;
  localparam logic [TIME_W-1:0] LIMIT_RESET  = 32'd1048576;
  localparam logic [TIME_W-1:0] TIME_SAT     = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [ACT_W-1:0]  active_sites;
    logic [TIME_W-1:0] time_limit;
  } cfg_t;

  typedef struct packed {
    logic [SITE_W-1:0] winner;
    logic              done_res;
    logic [TIME_W-1:0] event_time;
  } res_t;

endpackage

// ===== rtl/core/pcne_alarm_mem.sv =====
// alarm time storage: one write port, one read port, registered read data
module pcne_alarm_mem #(
  parameter int DEPTH = 64,
  parameter int AW    = 6
) (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [AW-1:0]             waddr_i,
  input  logic [pcne_pkg::TIME_W-1:0] wdata_i,
  input  logic                      re_i,
  input  logic [AW-1:0]             raddr_i,
  output logic [pcne_pkg::TIME_W-1:0] rdata_o
);
  import pcne_pkg::*;

  logic [TIME_W-1:0] mem_q [DEPTH];
  logic [TIME_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/pcne_ctrl.sv =====
// scan sequencer: min search over the alarm memory and write-back of the winner
module pcne_ctrl #(
  parameter int MAX_SITES = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic                  in_action_i,
  input  logic [pcne_pkg::SITE_W-1:0] in_site_i,
  input  logic [pcne_pkg::TIME_W-1:0] in_amount_i,
  input  pcne_pkg::cfg_t        cfg_i,
  input  logic                  out_free_i,
  output logic                  res_push_o,
  output pcne_pkg::res_t        res_o,
  output logic                  mem_we_o,
  output logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] mem_waddr_o,
  output logic [pcne_pkg::TIME_W-1:0] mem_wdata_o,
  output logic                  mem_re_o,
  output logic [((MAX_SITES > 1) ? $clog2(MAX_SITES) : 1)-1:0] mem_raddr_o,
  input  logic [pcne_pkg::TIME_W-1:0] mem_rdata_i
);
  import pcne_pkg::*;

  localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;
  localparam int CW = $clog2(MAX_SITES + 1);
  localparam logic [CW-1:0] N_MAX = CW'(MAX_SITES);
  localparam logic [CW-1:0] N_ONE = CW'(1);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_FINISH = 2'd2;

  logic [1:0]        state_q, state_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [CW-1:0]     n_q, n_d;
  logic              rd_vld_q, rd_vld_d;
  logic              first_q, first_d;
  logic [AW-1:0]     rd_idx_q, rd_idx_d;
  logic [AW-1:0]     best_idx_q, best_idx_d;
  logic [TIME_W-1:0] best_q, best_d;
  logic [TIME_W-1:0] amt_q, amt_d;

  logic              in_fire;
  logic              site_ok;
  logic              issue;
  logic              done;
  logic [TIME_W:0]   sum;
  logic [TIME_W-1:0] sum_sat;
  logic [CW-1:0]     n_scan;

  always_comb begin
    // zero counts as one, anything past the memory depth is clipped
    if (cfg_i.active_sites == '0) begin
      n_scan = N_ONE;
    end else if (32'(cfg_i.active_sites) > 32'(MAX_SITES)) begin
      n_scan = N_MAX;
    end else begin
      n_scan = CW'(cfg_i.active_sites);
    end
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i & in_ready_o;
  assign site_ok    = 32'(in_site_i) < 32'(MAX_SITES);
  assign issue      = (state_q == ST_SCAN) && (cnt_q != n_q);

  assign done    = !(best_q < cfg_i.time_limit);
  assign sum     = {1'b0, best_q} + {1'b0, amt_q};
  assign sum_sat = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];

  assign res_push_o = (state_q == ST_FINISH) && out_free_i;
  assign res_o.winner     = SITE_W'(best_idx_q);
  assign res_o.done_res   = done;
  assign res_o.event_time = best_q;

  assign mem_re_o    = issue;
  assign mem_raddr_o = cnt_q[AW-1:0];

  // loads write only from idle, write-back only after the scan has drained,
  // so no read is ever in flight against a pending write
  always_comb begin
    if (state_q == ST_FINISH) begin
      mem_we_o    = res_push_o && !done;
      mem_waddr_o = best_idx_q;
      mem_wdata_o = sum_sat;
    end else begin
      mem_we_o    = in_fire && (in_action_i == ACT_LOAD) && site_ok;
      mem_waddr_o = AW'(in_site_i);
      mem_wdata_o = in_amount_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    rd_vld_d   = issue;
    first_d    = first_q;
    rd_idx_d   = issue ? cnt_q[AW-1:0] : rd_idx_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    amt_d      = amt_q;

    if (rd_vld_q && (first_q || (mem_rdata_i < best_q))) begin
      best_d     = mem_rdata_i;
      best_idx_d = rd_idx_q;
      first_d    = 1'b0;
    end
    if (issue) begin
      cnt_d = cnt_q + N_ONE;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_fire && (in_action_i == ACT_STEP)) begin
          state_d = ST_SCAN;
          cnt_d   = '0;
          n_d     = n_scan;
          first_d = 1'b1;
          amt_d   = in_amount_i;
        end
      end
      ST_SCAN: begin
        if ((cnt_q == n_q) && !rd_vld_q) begin
          state_d = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (out_free_i) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      cnt_q    <= '0;
      rd_vld_q <= 1'b0;
      first_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rd_vld_q <= rd_vld_d;
      first_q  <= first_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q        <= n_d;
    rd_idx_q   <= rd_idx_d;
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
    amt_q      <= amt_d;
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (cnt_q <= n_q))
    else $error("scan counter ran past the active count");

  a_wb_only_below_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == ST_FINISH) && mem_we_o) |-> (best_q < cfg_i.time_limit))
    else $error("alarm written back on a done result");

  a_read_data_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SCAN))
    else $error("read data returned outside the scan");

  a_push_then_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push_o |=> (state_q == ST_IDLE))
    else $error("sequencer did not return to idle after a result");

endmodule

// ===== rtl/core/poisson_clock_next_event.sv =====
// next-event selection over per-site alarm clocks, stream ports and config registers
// a load beat is written in the cycle it is taken and gives no result
// a step beat scans alarms 0 to n - 1 one read a cycle, n = clamped active site count,
// and takes no new beat until its result is pushed into the output register; the result
// sits there, so the next beat is taken while it waits
// reset: asynchronous active low; config returns to 64 sites and limit 16.0, alarms keep
// whatever they held and must be loaded before a step reads them
module poisson_clock_next_event #(
  parameter int MAX_SITES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [5:0] site, [37:6] amount, [39:38] zero
  input  logic        s_axis_tuser,   // [0] action (0 load, 1 step)
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // [5:0] winner, [37:6] event_time, [39:38] zero
  output logic        m_axis_tuser,   // [0] done_res
  // config write port
  input  logic        cfg_we_i,
  input  logic [pcne_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0] cfg_data_i
);
  import pcne_pkg::*;

  localparam int AW = (MAX_SITES > 1) ? $clog2(MAX_SITES) : 1;

  // config registers
  cfg_t cfg_q, cfg_d;

  // result register toward the master side
  logic out_valid_q, out_valid_d;
  res_t out_res_q, out_res_d;

  logic              out_free;
  logic              res_push;
  res_t              res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [TIME_W-1:0] mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [TIME_W-1:0] mem_rdata;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ACTIVE_SITES: cfg_d.active_sites = cfg_data_i[ACT_W-1:0];
        CFG_TIME_LIMIT:   cfg_d.time_limit   = cfg_data_i[TIME_W-1:0];
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.active_sites <= ACTIVE_RESET;
      cfg_q.time_limit   <= LIMIT_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // output slot frees up in the same cycle its beat is taken
  assign out_free    = !out_valid_q || m_axis_tready;
  assign out_valid_d = res_push || (out_valid_q && !m_axis_tready);
  assign out_res_d   = res_push ? res : out_res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_res_q <= out_res_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.event_time, out_res_q.winner};
  assign m_axis_tuser  = out_res_q.done_res;

  pcne_ctrl #(
    .MAX_SITES (MAX_SITES)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_action_i (s_axis_tuser),
    .in_site_i   (s_axis_tdata[5:0]),
    .in_amount_i (s_axis_tdata[37:6]),
    .cfg_i       (cfg_q),
    .out_free_i  (out_free),
    .res_push_o  (res_push),
    .res_o       (res),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  pcne_alarm_mem #(
    .DEPTH (MAX_SITES),
    .AW    (AW)
  ) u_alarm_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  a_out_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result beat changed while stalled");

  a_no_push_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> out_free)
    else $error("result pushed into an occupied output slot");

  a_busy_while_result_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_push |-> !s_axis_tready)
    else $error("input taken in the result cycle");

endmodule

// ===== tb/sv/pcne_event_checker.sv =====
// result checker for the next-event block: own alarm predictor, expected-result queue, compare
module pcne_event_checker #(
  parameter int MAX_SITES = 64
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  input  logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,   // [5:0] site, [37:6] amount, [39:38] zero
  input  logic                           s_axis_tuser,   // [0] action
  input  logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic [39:0]                    m_axis_tdata,   // [5:0] winner, [37:6] event_time, [39:38] zero
  input  logic                           m_axis_tuser,   // [0] done_res
  input  logic                           cfg_we_i,
  input  logic [pcne_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                    cfg_data_i,
  output int unsigned                    error_cnt_o,
  output int unsigned                    pending_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import pcne_pkg::*;

  logic [TIME_W-1:0] alarm_mem [MAX_SITES];
  logic [ACT_W-1:0]  n_sites;
  logic [TIME_W-1:0] end_time;
  res_t              pending_events [$];
  int unsigned       error_cnt = 0;
  int unsigned       n_pending = 0;

  assign error_cnt_o = error_cnt;
  assign pending_o   = n_pending;

  task automatic report_mismatch(input string what);
    $display("%0t: %s", $time, what);
    error_cnt++;
  endtask

  // earliest active alarm, ties to the lowest index; advances it when below the end time
  function automatic void next_event(input logic [TIME_W-1:0] incr, output res_t r);
    int unsigned       n;
    int unsigned       best;
    logic [TIME_W-1:0] best_t;
    logic [TIME_W:0]   sum;
    n = (n_sites == 0) ? 1 : ((n_sites > MAX_SITES) ? MAX_SITES : n_sites);
    best = 0;
    best_t = alarm_mem[0];
    for (int i = 1; i < n; i++) begin
      if (alarm_mem[i] < best_t) begin
        best_t = alarm_mem[i];
        best = i;
      end
    end
    r.winner = best[SITE_W-1:0];
    r.done_res = !(best_t < end_time);
    r.event_time = best_t;
    if (!r.done_res) begin
      sum = {1'b0, best_t} + {1'b0, incr};
      alarm_mem[best] = sum[TIME_W] ? TIME_SAT : sum[TIME_W-1:0];
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    res_t seen;
    res_t want;
    if (!rst_ni) begin
      n_sites = ACTIVE_RESET;
      end_time = LIMIT_RESET;
      pending_events.delete();
    end else begin
      // results first, so a step taken at this edge cannot match an older beat
      if (m_axis_tvalid && m_axis_tready) begin
        seen.winner = m_axis_tdata[5:0];
        seen.event_time = m_axis_tdata[37:6];
        seen.done_res = m_axis_tuser;
        if (pending_events.size() == 0) begin
          report_mismatch($sformatf("unexpected result: winner %0d done %0b time %08h",
                                    seen.winner, seen.done_res, seen.event_time));
        end else begin
          want = pending_events.pop_front();
          if (seen.winner !== want.winner)
            report_mismatch($sformatf("winner: got %0d want %0d", seen.winner, want.winner));
          if (seen.done_res !== want.done_res)
            report_mismatch($sformatf("done_res: got %0b want %0b",
                                      seen.done_res, want.done_res));
          if (seen.event_time !== want.event_time)
            report_mismatch($sformatf("event_time: got %08h want %08h",
                                      seen.event_time, want.event_time));
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser == ACT_LOAD) begin
          if (s_axis_tdata[5:0] < MAX_SITES)
            alarm_mem[s_axis_tdata[5:0]] = s_axis_tdata[37:6];
        end else begin
          next_event(s_axis_tdata[37:6], want);
          pending_events = {pending_events, want};
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_ACTIVE_SITES: n_sites = cfg_data_i[ACT_W-1:0];
          CFG_TIME_LIMIT:   end_time = cfg_data_i;
          default: ;
        endcase
      end
    end
    n_pending = pending_events.size();
  end

endmodule

// ===== tb/sv/poisson_clock_next_event_test.sv =====
// top of the next-event block test: clock, reset, stimulus, stall patterns and verdict
module poisson_clock_next_event_test;
  timeunit 1ns;
  timeprecision 1ps;
  import pcne_pkg::*;

  localparam int          SITES     = 64;
  localparam int unsigned RUN_LIMIT = 1000000;  // cycles before the watchdog gives up
  localparam int unsigned HOLD_LEN  = 400;      // long receiver hold-off
  localparam int unsigned DRAIN_PAD = 80;       // a full 64-site scan plus margin

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [39:0]          s_axis_tdata = '0;    // [5:0] site, [37:6] amount, [39:38] zero
  logic                 s_axis_tuser = 1'b0;  // [0] action
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [39:0]          m_axis_tdata;         // [5:0] winner, [37:6] event_time, [39:38] zero
  logic                 m_axis_tuser;         // [0] done_res
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [31:0]          cfg_data_i = '0;

  int unsigned error_cnt;
  int unsigned pending;
  int unsigned cycle_cnt = 0;

  // stimulus knobs; rx_no_gaps and rx_hold_req are shared with the receiver process
  bit          tx_no_gaps = 1'b0;
  bit          rx_no_gaps = 1'b0;
  bit          rx_hold_req = 1'b0;
  logic [31:0] cur_limit = LIMIT_RESET;
  int unsigned scan_n = SITES;

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  poisson_clock_next_event #(
    .MAX_SITES(SITES)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  pcne_event_checker #(
    .MAX_SITES(SITES)
  ) u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .error_cnt_o   (error_cnt),
    .pending_o     (pending)
  );

  // one input beat: optional gap with valid low, then hold valid until taken
  task automatic push_item(input logic act, input logic [SITE_W-1:0] site,
                           input logic [TIME_W-1:0] amount);
    int unsigned gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 16);
    if (gap != 0) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, amount, site};
    s_axis_tuser  <= act;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // sender goes quiet until every step has reported, plus a few cycles for late loads
  task automatic quiesce();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  // new settings; upper data bits carry noise that the active count must ignore
  task automatic set_config(input logic [ACT_W-1:0] act, input logic [31:0] lim);
    write_reg(CFG_ACTIVE_SITES, ($urandom() & 32'hFFFF_FF80) | act);
    write_reg(CFG_TIME_LIMIT, lim);
    cur_limit = lim;
    scan_n = (act == 0) ? 1 : ((act > SITES) ? SITES : act);
  endtask

  // start times that will still give events under the current end time (any value when it is zero)
  function automatic logic [31:0] below_limit();
    if (cur_limit == 0) return $urandom();
    return $urandom_range(0, cur_limit - 1);
  endfunction

  // mostly short exponential-like increments, with zero, max and wild values mixed in
  function automatic logic [31:0] draw_incr();
    int unsigned pick;
    pick = $urandom_range(0, 15);
    if (pick == 0) return '0;
    if (pick == 1) return TIME_SAT;
    if (pick <= 3) return $urandom();
    return $urandom_range(0, 32'h0004_0000) >> $urandom_range(0, 6);
  endfunction

  // receiver: random stall per beat, no-stall stretches, one long hold-off on request
  initial begin
    int unsigned stall;
    wait (rst_ni);
    forever begin
      stall = rx_no_gaps ? 0 : $urandom_range(0, 16);
      if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = HOLD_LEN;
      end
      if (stall != 0) begin
        @(negedge clk_i);
        m_axis_tready <= 1'b0;
        for (int k = 1; k < stall; k++) @(negedge clk_i);
      end
      @(negedge clk_i);
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // watchdog
  initial begin
    while (cycle_cnt < RUN_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    int unsigned       issued;
    int unsigned       nload;
    int unsigned       nstep;
    bit                paused;
    logic [ACT_W-1:0]  act;
    logic [31:0]       lim;
    logic [31:0]       tie_val;
    logic [31:0]       val;
    logic [SITE_W-1:0] site;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // every site gets a start time before any step can read it
    for (int i = 0; i < SITES; i++)
      push_item(ACT_LOAD, SITE_W'(i), $urandom_range(0, LIMIT_RESET - 1));

    // reset settings: zero increment keeps the same site earliest, ties at the top end
    push_item(ACT_STEP, '0, '0);
    push_item(ACT_LOAD, 6'd63, '0);
    push_item(ACT_LOAD, 6'd62, '0);
    push_item(ACT_STEP, '0, 32'h0000_0001);
    push_item(ACT_STEP, '0, TIME_SAT);

    // count zero means site 0 alone; overflowing add saturates, saturated alarm is done
    quiesce();
    set_config(7'd0, TIME_SAT);
    push_item(ACT_LOAD, '0, 32'h8000_0000);
    push_item(ACT_STEP, '0, TIME_SAT);
    push_item(ACT_STEP, '0, 32'h0000_1000);
    push_item(ACT_LOAD, '0, 32'hFFFF_FFFE);
    push_item(ACT_STEP, '0, 32'h0000_0001);
    push_item(ACT_STEP, '0, '0);

    // oversized count clamps to all sites, zero end time makes every step done
    quiesce();
    set_config(7'd127, 32'h0000_0000);
    push_item(ACT_STEP, '0, 32'h0001_0000);
    push_item(ACT_LOAD, 6'd40, '0);
    push_item(ACT_STEP, '0, 32'h0001_0000);

    // two sites: one sits exactly at the end time, the other just under it, then a tie
    quiesce();
    set_config(7'd2, 32'h0001_0000);
    push_item(ACT_LOAD, '0, 32'h0001_0000);
    push_item(ACT_LOAD, 6'd1, 32'h0000_FFFF);
    push_item(ACT_STEP, '0, '0);
    push_item(ACT_STEP, '0, 32'h0000_0001);
    push_item(ACT_STEP, '0, 32'h0000_0001);

    // random phases, each under its own settings
    for (int ph = 0; ph < 12; ph++) begin
      quiesce();
      case (ph)
        0: begin act = 7'd1;   lim = TIME_SAT;      end
        1: begin act = 7'd127; lim = LIMIT_RESET;   end
        2: begin act = 7'd64;  lim = 32'h0000_0000; end
        3: begin act = 7'd3;   lim = $urandom();    end
        default: begin
          case ($urandom_range(0, 3))
            0:       act = ACT_W'($urandom_range(0, 127));
            1:       act = ACT_W'($urandom_range(1, 4));
            default: act = ACT_W'($urandom_range(1, 64));
          endcase
          case ($urandom_range(0, 3))
            0:       lim = LIMIT_RESET;
            1:       lim = $urandom();
            2:       lim = TIME_SAT;
            default: lim = $urandom_range(32'h0000_0100, 32'h0040_0000);
          endcase
        end
      endcase
      set_config(act, lim);
      tx_no_gaps = ($urandom_range(0, 3) == 0);
      rx_no_gaps = ($urandom_range(0, 3) == 0);
      // the receiver stops for a long while, the block fills and holds off the sender
      if (ph == 4) begin
        tx_no_gaps = 1'b1;
        rx_hold_req = 1'b1;
      end
      tie_val = below_limit();
      issued = 0;
      paused = 1'b0;
      while (issued < 88) begin
        // once, halfway through, the sender waits for every result to drain
        if (ph == 6 && !paused && issued >= 44) begin
          quiesce();
          paused = 1'b1;
        end
        if ($urandom_range(0, 9) < 7) begin
          // refill a few sites with start times under the end time (any value when it is zero), then run steps
          nload = $urandom_range(1, 3);
          nstep = $urandom_range(2, 8);
          repeat (nload) begin
            site = ($urandom_range(0, 7) == 0) ? SITE_W'($urandom_range(0, SITES - 1))
                                               : SITE_W'($urandom_range(0, scan_n - 1));
            val = ($urandom_range(0, 3) == 0) ? tie_val : below_limit();
            push_item(ACT_LOAD, site, val);
          end
          repeat (nstep)
            push_item(ACT_STEP, SITE_W'($urandom_range(0, SITES - 1)), draw_incr());
          issued += nload + nstep;
        end else begin
          // noise: wild start time anywhere, or a step with a raw increment
          if ($urandom_range(0, 1) == 0)
            push_item(ACT_LOAD, SITE_W'($urandom_range(0, SITES - 1)), $urandom());
          else
            push_item(ACT_STEP, SITE_W'($urandom_range(0, SITES - 1)), $urandom());
          issued++;
        end
      end
    end

    quiesce();
    repeat (DRAIN_PAD) @(negedge clk_i);
    if (error_cnt == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/pcne_pkg.sv
rtl/core/pcne_alarm_mem.sv
rtl/core/pcne_ctrl.sv
rtl/core/poisson_clock_next_event.sv
tb/sv/pcne_event_checker.sv
tb/sv/poisson_clock_next_event_test.sv
